// ===== rtl/core/value_noise_sampler_2d_unit_assert.svh =====
// Assertion macros for the value noise sampler.
// Both macros sample on the rising edge of clock.
`ifndef VALUE_NOISE_SAMPLER_2D_UNIT_ASSERT_SVH
`define VALUE_NOISE_SAMPLER_2D_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VNS_ASSERT_CLK(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) expr) \
      else $error("vns assertion failed");
`define VNS_ASSERT_RAW(label, expr) \
   label: assert property (@(posedge clock) expr) \
      else $error("vns assertion failed");
`else
`define VNS_ASSERT_CLK(label, expr)
`define VNS_ASSERT_RAW(label, expr)
`endif
`endif

// ===== rtl/core/vns_pkg.sv =====
`timescale 1ns / 1ps
package vns_pkg;
   localparam int NUM_STAGES  = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int SIDE_LOG2_W = 5;
   localparam int FREQ_W      = 24;
   localparam int AMP_W       = 24;
   localparam int NOISE_W     = 24;
   localparam int POS_W       = 32;
   localparam int LAT_W       = 32;
   localparam int VALUE_W     = 36;   // smoothed lattice value, 2^-34 units
   localparam int AMP_RSHIFT  = 34;

   localparam logic [31:0] HASH_MUL_Y    = 32'd57;
   localparam logic [31:0] HASH_MUL_SEED = 32'd131;
   localparam int          HASH_SHIFT    = 13;
   localparam logic [31:0] HASH_K1       = 32'd15731;
   localparam logic [31:0] HASH_K2       = 32'd789221;
   localparam logic [31:0] HASH_K3       = 32'd1376312589;
   localparam logic [31:0] HASH_MASK     = 32'h7fff_ffff;
   localparam logic [31:0] LATTICE_ONE   = 32'h4000_0000;

   localparam logic [31:0]            SEED_RST      = 32'd0;
   localparam logic [SIDE_LOG2_W-1:0] SIDE_LOG2_RST = 5'd6;
   localparam logic [FREQ_W-1:0]      FREQ_RST      = 24'd65536;
   localparam logic [AMP_W-1:0]       AMP_RST       = 24'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEED      = 3'd0,
      CSR_SIDE_LOG2 = 3'd1,
      CSR_FREQUENCY = 3'd2,
      CSR_AMPLITUDE = 3'd3,
      CSR_OFFSET_X  = 3'd4,
      CSR_OFFSET_Y  = 3'd5
   } csr_index_type;

   // load strobe per pipeline stage, stage 1 nearest the input
   typedef struct packed {
      logic [NUM_STAGES:1] load;
   } pipe_ctl_type;
endpackage

// ===== rtl/core/vns_hash.sv =====
`timescale 1ns / 1ps
// Lattice hash of one point, stages 4 to 7.
module vns_hash #(
   parameter int MAX_SIDE_LOG2 = 16
) (
   input  logic                         clock,
   input  vns_pkg::pipe_ctl_type        ctl,
   input  logic [MAX_SIDE_LOG2-1:0]     x_coord,
   input  logic [MAX_SIDE_LOG2-1:0]     y_coord,
   input  logic [31:0]                  seed,
   output logic signed [vns_pkg::LAT_W-1:0] lattice
);
   logic [31:0] mix;
   logic [31:0] n_in, n_ff;
   logic [31:0] nn_in, nn_ff, n5_ff;
   logic [31:0] t_in, t_ff, n6_ff;
   logic [31:0] h;
   logic signed [vns_pkg::LAT_W-1:0] lat_in, lat_ff;

   assign mix    = 32'(x_coord) + 32'(y_coord) * vns_pkg::HASH_MUL_Y
                 + seed * vns_pkg::HASH_MUL_SEED;
   assign n_in   = (mix << vns_pkg::HASH_SHIFT) ^ mix;
   assign nn_in  = n_ff * n_ff;
   assign t_in   = nn_ff * vns_pkg::HASH_K1 + vns_pkg::HASH_K2;
   assign h      = (n6_ff * t_ff + vns_pkg::HASH_K3) & vns_pkg::HASH_MASK;
   assign lat_in = $signed(vns_pkg::LATTICE_ONE - h);

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         n_ff <= n_in;
      end
      if (ctl.load[5]) begin
         nn_ff <= nn_in;
         n5_ff <= n_ff;
      end
      if (ctl.load[6]) begin
         t_ff  <= t_in;
         n6_ff <= n5_ff;
      end
      if (ctl.load[7]) begin
         lat_ff <= lat_in;
      end
   end

   assign lattice = lat_ff;
endmodule

// ===== rtl/core/vns_front.sv =====
`timescale 1ns / 1ps
// Offset, scale, cell split and smoothstep weights, stages 1 to 7.
module vns_front #(
   parameter int FRAC_BITS     = 16,
   parameter int MAX_SIDE_LOG2 = 16
) (
   input  logic                                  clock,
   input  vns_pkg::pipe_ctl_type                 ctl,
   input  logic signed [vns_pkg::POS_W-1:0]      pos_x,
   input  logic signed [vns_pkg::POS_W-1:0]      pos_y,
   input  logic signed [vns_pkg::POS_W-1:0]      offset_x,
   input  logic signed [vns_pkg::POS_W-1:0]      offset_y,
   input  logic [vns_pkg::FREQ_W-1:0]            frequency,
   input  logic [vns_pkg::SIDE_LOG2_W-1:0]       side_log2,
   output logic [MAX_SIDE_LOG2-1:0]              x_coord [4],
   output logic [MAX_SIDE_LOG2-1:0]              y_coord [4],
   output logic [FRAC_BITS:0]                    s_x,
   output logic [FRAC_BITS:0]                    s_y
);
   localparam int SUM_W  = vns_pkg::POS_W + 1;
   localparam int PROD_W = SUM_W + vns_pkg::FREQ_W;
   localparam int FIX_SH = 32;

   logic signed [SUM_W-1:0]     sum_ff   [2];
   logic signed [PROD_W-1:0]    prod_ff  [2];
   logic [MAX_SIDE_LOG2-1:0]    coord_in [2][4];
   logic [MAX_SIDE_LOG2-1:0]    coord_ff [2][4];
   logic [FRAC_BITS-1:0]        frac_ff  [2];
   logic [FRAC_BITS-1:0]        frac4_ff [2];
   logic [2*FRAC_BITS-1:0]      fsq_ff   [2];
   logic [2*FRAC_BITS+1:0]      sp_ff    [2];
   logic [FRAC_BITS:0]          s6_ff    [2];
   logic [FRAC_BITS:0]          s7_ff    [2];
   logic signed [vns_pkg::POS_W-1:0] pos [2];
   logic signed [vns_pkg::POS_W-1:0] off [2];
   logic [vns_pkg::SIDE_LOG2_W-1:0]  lg;
   logic [MAX_SIDE_LOG2-1:0]         mask;
   logic [MAX_SIDE_LOG2-1:0]         cell_idx [2];

   assign pos[0] = pos_x;
   assign pos[1] = pos_y;
   assign off[0] = offset_x;
   assign off[1] = offset_y;

   // side clamped to 1..MAX_SIDE_LOG2
   always_comb begin
      if (side_log2 == '0) begin
         lg = vns_pkg::SIDE_LOG2_W'(1);
      end else if (side_log2 > vns_pkg::SIDE_LOG2_W'(MAX_SIDE_LOG2)) begin
         lg = vns_pkg::SIDE_LOG2_W'(MAX_SIDE_LOG2);
      end else begin
         lg = side_log2;
      end
      mask = ~({MAX_SIDE_LOG2{1'b1}} << lg);
   end

   // four neighbour columns/rows: cell-1 .. cell+2, wrapped
   always_comb begin
      for (int a = 0; a < 2; a++) begin
         cell_idx[a] = prod_ff[a][FIX_SH +: MAX_SIDE_LOG2];
         for (int k = 0; k < 4; k++) begin
            coord_in[a][k] = (cell_idx[a] + MAX_SIDE_LOG2'(k) - MAX_SIDE_LOG2'(1)) & mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 2; a++) begin
         if (ctl.load[1]) begin
            sum_ff[a] <= SUM_W'(pos[a]) + SUM_W'(off[a]);
         end
         if (ctl.load[2]) begin
            prod_ff[a] <= PROD_W'(sum_ff[a] * $signed({1'b0, frequency}));
         end
         if (ctl.load[3]) begin
            coord_ff[a] <= coord_in[a];
            frac_ff[a]  <= prod_ff[a][FIX_SH-FRAC_BITS +: FRAC_BITS];
         end
         if (ctl.load[4]) begin
            frac4_ff[a] <= frac_ff[a];
            fsq_ff[a]   <= frac_ff[a] * frac_ff[a];
         end
         if (ctl.load[5]) begin
            // f2 * (3*one - 2*f)
            sp_ff[a] <= (2*FRAC_BITS+2)'(fsq_ff[a][2*FRAC_BITS-1:FRAC_BITS])
                      * ((FRAC_BITS+2)'(3) << FRAC_BITS)
                      - (2*FRAC_BITS+2)'(fsq_ff[a][2*FRAC_BITS-1:FRAC_BITS])
                      * (FRAC_BITS+2)'({frac4_ff[a], 1'b0});
         end
         if (ctl.load[6]) begin
            s6_ff[a] <= sp_ff[a][2*FRAC_BITS:FRAC_BITS];
         end
         if (ctl.load[7]) begin
            s7_ff[a] <= s6_ff[a];
         end
      end
   end

   assign x_coord = coord_ff[0];
   assign y_coord = coord_ff[1];
   assign s_x     = s7_ff[0];
   assign s_y     = s7_ff[1];
endmodule

// ===== rtl/core/vns_blend.sv =====
`timescale 1ns / 1ps
// Corner smoothing, bilinear blend, amplitude scaling and saturation, stages 8 to 16.
module vns_blend #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  vns_pkg::pipe_ctl_type                  ctl,
   input  logic signed [vns_pkg::LAT_W-1:0]       lattice [16],
   input  logic [FRAC_BITS:0]                     s_x,
   input  logic [FRAC_BITS:0]                     s_y,
   input  logic signed [vns_pkg::AMP_W-1:0]       amplitude,
   output logic signed [vns_pkg::NOISE_W-1:0]     noise_value
);
   localparam int VW     = vns_pkg::VALUE_W;
   localparam int DW     = VW + 1;
   localparam int PW     = DW + FRAC_BITS + 2;
   localparam int RW     = VW + vns_pkg::AMP_W;
   localparam int SATW   = RW - vns_pkg::AMP_RSHIFT;
   localparam logic signed [SATW-1:0] SAT_MAX = SATW'(8388607);
   localparam logic signed [SATW-1:0] SAT_MIN = -SATW'(8388608);

   logic signed [VW-1:0] v_in [4];
   logic signed [VW-1:0] v_ff [4];
   logic [FRAC_BITS:0]   sx8_ff, sy8_ff, sx9_ff, sy9_ff, sy10_ff, sy11_ff, sy12_ff;
   logic signed [DW-1:0] d0_ff, d1_ff, dy_ff;
   logic signed [VW-1:0] a0_ff, a1_ff, a0p_ff, a1p_ff;
   logic signed [PW-1:0] p0_ff, p1_ff, q_ff;
   logic signed [VW-1:0] e0_ff, e1_ff, e0b_ff, e0c_ff, n_ff;
   logic signed [RW-1:0] r_ff;
   logic signed [SATW-1:0] r_sh;
   logic signed [vns_pkg::NOISE_W-1:0] out_in, out_ff;

   // weights 1 / 2 / 4 for corner / side / centre of the 3x3 kernel
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         v_in[c] = '0;
         for (int dj = 0; dj < 3; dj++) begin
            for (int di = 0; di < 3; di++) begin
               v_in[c] = v_in[c] + (VW'(lattice[(c%2+di) + 4*(c/2+dj)])
                         <<< ((di == 1 ? 1 : 0) + (dj == 1 ? 1 : 0)));
            end
         end
      end
   end

   always_comb begin
      r_sh = SATW'(r_ff >>> vns_pkg::AMP_RSHIFT);
      if (r_sh > SAT_MAX) begin
         out_in = vns_pkg::NOISE_W'(SAT_MAX);
      end else if (r_sh < SAT_MIN) begin
         out_in = vns_pkg::NOISE_W'(SAT_MIN);
      end else begin
         out_in = vns_pkg::NOISE_W'(r_sh);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[8]) begin
         v_ff   <= v_in;
         sx8_ff <= s_x;
         sy8_ff <= s_y;
      end
      if (ctl.load[9]) begin
         d0_ff  <= DW'(v_ff[1]) - DW'(v_ff[0]);
         d1_ff  <= DW'(v_ff[3]) - DW'(v_ff[2]);
         a0_ff  <= v_ff[0];
         a1_ff  <= v_ff[2];
         sx9_ff <= sx8_ff;
         sy9_ff <= sy8_ff;
      end
      if (ctl.load[10]) begin
         p0_ff   <= PW'($signed({1'b0, sx9_ff}) * d0_ff);
         p1_ff   <= PW'($signed({1'b0, sx9_ff}) * d1_ff);
         a0p_ff  <= a0_ff;
         a1p_ff  <= a1_ff;
         sy10_ff <= sy9_ff;
      end
      if (ctl.load[11]) begin
         e0_ff   <= a0p_ff + VW'(p0_ff >>> FRAC_BITS);
         e1_ff   <= a1p_ff + VW'(p1_ff >>> FRAC_BITS);
         sy11_ff <= sy10_ff;
      end
      if (ctl.load[12]) begin
         dy_ff   <= DW'(e1_ff) - DW'(e0_ff);
         e0b_ff  <= e0_ff;
         sy12_ff <= sy11_ff;
      end
      if (ctl.load[13]) begin
         q_ff   <= PW'($signed({1'b0, sy12_ff}) * dy_ff);
         e0c_ff <= e0b_ff;
      end
      if (ctl.load[14]) begin
         n_ff <= e0c_ff + VW'(q_ff >>> FRAC_BITS);
      end
      if (ctl.load[15]) begin
         r_ff <= RW'(n_ff * amplitude);
      end
      if (ctl.load[16]) begin
         out_ff <= out_in;
      end
   end

   assign noise_value = out_ff;
endmodule

// ===== rtl/core/value_noise_sampler_2d_unit.sv =====
`timescale 1ns / 1ps
// 2-D hashed lattice value noise sampler.
// Request channel: req_valid / req_stall carry one word, a Q16.16 position
// (req_pos_x, req_pos_y). Response channel: rsp_valid / rsp_stall carry
// rsp_noise_value, signed Q8.16, saturated. A word moves on a rising edge
// with valid high and stall low.
// Throughput: one word per clock while rsp_stall is low; every stage then takes one word per cycle.
// Pipeline stages, in order: offset, scale, cell split, four hash stages,
// smoothing, two lerps of three stages, amplitude, clamp.
// The csr_ port writes seed, side_log2, frequency, amplitude and the
// offsets; write only while the pipe is empty.
// Reset (synchronous) empties the pipe and restores register defaults.
// A stalled response holds; stages behind it keep filling bubbles and
// req_stall rises only when the word in stage 1 cannot move on.
`include "value_noise_sampler_2d_unit_assert.svh"
module value_noise_sampler_2d_unit #(
   parameter int FRAC_BITS     = 16,
   parameter int MAX_SIDE_LOG2 = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [vns_pkg::POS_W-1:0]       req_pos_x,
   input  logic signed [vns_pkg::POS_W-1:0]       req_pos_y,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [vns_pkg::NOISE_W-1:0]     rsp_noise_value,
   input  logic                                   csr_wr_en,
   input  logic [vns_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [vns_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   localparam int NS = vns_pkg::NUM_STAGES;

   logic [31:0]                            seed_ff;
   logic [vns_pkg::SIDE_LOG2_W-1:0]        side_log2_ff;
   logic [vns_pkg::FREQ_W-1:0]             frequency_ff;
   logic signed [vns_pkg::AMP_W-1:0]       amplitude_ff;
   logic signed [vns_pkg::POS_W-1:0]       offset_x_ff, offset_y_ff;

   logic [NS:1]           v_ff, v_in;
   logic [NS:1]           ready;
   vns_pkg::pipe_ctl_type ctl;
   logic                  in_acc, out_acc;

   logic [MAX_SIDE_LOG2-1:0]           x_coord [4];
   logic [MAX_SIDE_LOG2-1:0]           y_coord [4];
   logic [FRAC_BITS:0]                 s_x, s_y;
   logic signed [vns_pkg::LAT_W-1:0]   lattice [16];

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= vns_pkg::SEED_RST;
         side_log2_ff <= vns_pkg::SIDE_LOG2_RST;
         frequency_ff <= vns_pkg::FREQ_RST;
         amplitude_ff <= vns_pkg::AMP_RST;
         offset_x_ff  <= '0;
         offset_y_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            vns_pkg::CSR_SEED:      seed_ff      <= csr_wdata;
            vns_pkg::CSR_SIDE_LOG2: side_log2_ff <= csr_wdata[vns_pkg::SIDE_LOG2_W-1:0];
            vns_pkg::CSR_FREQUENCY: frequency_ff <= csr_wdata[vns_pkg::FREQ_W-1:0];
            vns_pkg::CSR_AMPLITUDE: amplitude_ff <= $signed(csr_wdata[vns_pkg::AMP_W-1:0]);
            vns_pkg::CSR_OFFSET_X:  offset_x_ff  <= $signed(csr_wdata);
            vns_pkg::CSR_OFFSET_Y:  offset_y_ff  <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // a stage loads when it is empty or its word moves on
   always_comb begin
      ready[NS] = !v_ff[NS] || !rsp_stall;
      for (int k = NS - 1; k >= 1; k--) begin
         ready[k] = !v_ff[k] || ready[k+1];
      end
      v_in = v_ff;
      if (ready[1]) begin
         v_in[1] = req_valid;
      end
      for (int k = 2; k <= NS; k++) begin
         if (ready[k]) begin
            v_in[k] = v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign ctl.load  = ready;
   assign req_stall = !ready[1];
   assign rsp_valid = v_ff[NS];
   assign in_acc    = req_valid && !req_stall;
   assign out_acc   = rsp_valid && !rsp_stall;

   vns_front #(
      .FRAC_BITS    (FRAC_BITS),
      .MAX_SIDE_LOG2(MAX_SIDE_LOG2)
   ) u_front (
      .clock    (clock),
      .ctl      (ctl),
      .pos_x    (req_pos_x),
      .pos_y    (req_pos_y),
      .offset_x (offset_x_ff),
      .offset_y (offset_y_ff),
      .frequency(frequency_ff),
      .side_log2(side_log2_ff),
      .x_coord  (x_coord),
      .y_coord  (y_coord),
      .s_x      (s_x),
      .s_y      (s_y)
   );

   // 4x4 neighbourhood, column index i, row index j
   for (genvar g = 0; g < 16; g++) begin : g_hash
      vns_hash #(
         .MAX_SIDE_LOG2(MAX_SIDE_LOG2)
      ) u_hash (
         .clock  (clock),
         .ctl    (ctl),
         .x_coord(x_coord[g % 4]),
         .y_coord(y_coord[g / 4]),
         .seed   (seed_ff),
         .lattice(lattice[g])
      );
   end

   vns_blend #(
      .FRAC_BITS(FRAC_BITS)
   ) u_blend (
      .clock      (clock),
      .ctl        (ctl),
      .lattice    (lattice),
      .s_x        (s_x),
      .s_y        (s_y),
      .amplitude  (amplitude_ff),
      .noise_value(rsp_noise_value)
   );

   // words in flight change only by what enters and leaves
   `VNS_ASSERT_CLK(a_occupancy, !$past(reset) |-> $countones(v_ff) == $past($countones(v_ff)) + $past(in_acc) - $past(out_acc))
   // a free output never back-pressures the input
   `VNS_ASSERT_CLK(a_no_stall_free, !rsp_stall |-> !req_stall)
   // pipe is empty once reset is released
   `VNS_ASSERT_RAW(a_reset_empty, $past(reset) && !reset |-> v_ff == '0)
endmodule
